[rtl/sdta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdta_pkg - shared types and constants
// Widths, ASCII codes and the control word that steps the BCD digit cells.
// ----------------------------------------------------------------------------
package sdta_pkg;

	localparam int VAL_W      = 32;
	localparam int CODE_W     = 6;
	localparam int NUM_DIGITS = 10;
	localparam int BIT_CNT_W  = $clog2(VAL_W);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CODE_W-1:0] CHAR_MINUS = 6'd45;

	typedef logic [3:0] digit_t;

	// one-hot sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	// control word broadcast to every digit cell
	typedef struct packed {
		logic clear; // load zero
		logic conv;  // add-3 adjust, then shift in one binary bit
		logic shift; // take the neighbouring lower digit
	} cell_ctrl_t;

endpackage

[rtl/sdta_digit_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdta_digit_cell - one BCD digit of the conversion chain
// Double-dabble step (adjust by three, shift one bit up) or plain digit shift
// towards the most significant end for output.
// ----------------------------------------------------------------------------
module sdta_digit_cell (
	input  logic                clk,
	input  sdta_pkg::cell_ctrl_t ctrl,
	input  logic                bit_in,
	input  sdta_pkg::digit_t    digit_in,
	output logic                bit_out,
	output sdta_pkg::digit_t    digit_q
);
	import sdta_pkg::*;

	digit_t adj;

	assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = adj[3];

	always_ff @(posedge clk) begin
		priority if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.conv) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

[rtl/signed_int_to_decimal_ascii_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core - signed 32-bit integer to decimal ASCII
// Emits the decimal text of each value one character per transfer, most
// significant first, with a leading minus for negative values.
// ----------------------------------------------------------------------------
// One value is taken at a time. After the input transfer the magnitude is
// fed one bit per cycle into a chain of ten BCD digit cells (double dabble);
// the chain then shifts its digits out towards the top, one per cycle while
// the output is not stalled, dropping leading zeros without output. The next
// input transfer waits until the last digit has been loaded into the output
// register. Up to eleven characters come out, the last flagged by last_char.
// The final character may still sit in the output register while the next
// value is taken.
module signed_int_to_decimal_ascii_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [sdta_pkg::VAL_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sdta_pkg::CODE_W-1:0]      char_code,
	output logic                             last_char
);
	import sdta_pkg::*;

	state_t                 state_q;
	logic [VAL_W-1:0]       mag_q;
	logic [VAL_W-1:0]       raw;
	logic [VAL_W-1:0]       mag_in;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   dig_cnt_q;
	logic                   sign_pend_q;
	logic                   seen_q;
	logic                   ov_q;
	logic [CODE_W-1:0]      code_q;
	logic                   last_q;

	cell_ctrl_t             ctrl;
	digit_t                 digits [NUM_DIGITS];
	logic                   carry  [NUM_DIGITS-1];
	digit_t                 top_dig;

	logic accept, in_emit, last_dig, skip, load_ok, load_sign, load_dig;

	assign raw    = value;
	assign mag_in = raw[VAL_W-1] ? (~raw + VAL_W'(1)) : raw;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign in_emit   = (state_q == ST_EMIT);
	assign top_dig   = digits[NUM_DIGITS-1];
	assign last_dig  = (dig_cnt_q == DIG_CNT_W'(1));
	// leading zeros walk out of the chain without a transfer
	assign skip      = in_emit && !seen_q && (top_dig == 4'd0) && !last_dig;
	assign load_ok   = !ov_q || !out_stall;
	assign load_sign = in_emit && sign_pend_q && load_ok;
	assign load_dig  = in_emit && !sign_pend_q && !skip && load_ok;

	assign ctrl.clear = accept;
	assign ctrl.conv  = (state_q == ST_CONV);
	assign ctrl.shift = skip || load_dig;

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		logic   bit_in_w;
		digit_t dig_in_w;

		if (i == 0) begin : g_lsd
			assign bit_in_w = mag_q[VAL_W-1];
			assign dig_in_w = '0;
		end else begin : g_mid
			assign bit_in_w = carry[i-1];
			assign dig_in_w = digits[i-1];
		end

		if (i == NUM_DIGITS - 1) begin : g_top
			sdta_digit_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.bit_in   (bit_in_w),
				.digit_in (dig_in_w),
				.bit_out  (),
				.digit_q  (digits[i])
			);
		end else begin : g_low
			sdta_digit_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.bit_in   (bit_in_w),
				.digit_in (dig_in_w),
				.bit_out  (carry[i]),
				.digit_q  (digits[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			dig_cnt_q   <= '0;
			sign_pend_q <= 1'b0;
			seen_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sign_pend_q <= raw[VAL_W-1];
						bit_cnt_q   <= '0;
						state_q     <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
					if (bit_cnt_q == BIT_CNT_W'(VAL_W - 1)) begin
						dig_cnt_q <= DIG_CNT_W'(NUM_DIGITS);
						seen_q    <= 1'b0;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_sign) begin
						sign_pend_q <= 1'b0;
					end
					if (ctrl.shift) begin
						dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
					end
					if (load_dig) begin
						seen_q <= 1'b1;
						if (last_dig) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// magnitude shift register
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag_in;
		end else if (ctrl.conv) begin
			mag_q <= {mag_q[VAL_W-2:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else begin
			ov_q <= (load_sign || load_dig) ? 1'b1 : (ov_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load_sign) begin
			code_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (load_dig) begin
			code_q <= CHAR_ZERO | {2'b00, top_dig};
			last_q <= last_dig;
		end
	end

	assign out_valid = ov_q;
	assign char_code = code_q;
	assign last_char = last_q;

endmodule

[rtl/sdta_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdta_checker - port-level checks for the integer to ASCII core
// Watches the two channels and the character stream; bound to the top level.
// ----------------------------------------------------------------------------
module sdta_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [sdta_pkg::CODE_W-1:0] char_code,
	input logic                        last_char
);
	import sdta_pkg::*;

	// held output transfer keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last_char))
		else $error("output changed while stalled");

	// only minus or a digit ever leaves the block
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code == CHAR_MINUS) ||
			(char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 6'd9))
		else $error("character code out of range");

	// a minus sign never ends a run
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (char_code == CHAR_MINUS) |-> !last_char)
		else $error("minus flagged as last character");

	// after an input transfer the core is busy converting
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second value taken during conversion");

endmodule

bind signed_int_to_decimal_ascii_core sdta_checker u_sdta_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.char_code (char_code),
	.last_char (last_char)
);

[dv/tb_signed_int_to_decimal_ascii_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_core - self-checking bench for the itoa core
// A directed table of values is sent first, then random values of every digit
// count and sign. The decimal text of each accepted value is queued, and every
// character transfer is compared with the head of that queue.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_core;
	import sdta_pkg::*;

	typedef struct {
		logic [CODE_W-1:0] code;
		logic              last;
	} char_t;

	typedef struct {
		logic signed [VAL_W-1:0] val;
		string                   text; // empty: text comes from the predictor
	} row_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic signed [VAL_W-1:0] value     = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [CODE_W-1:0]       char_code;
	logic                    last_char;

	char_t pending_chars[$];
	row_t  values_q[$];
	int    err_cnt   = 0;
	int    rx_cyc    = 0;
	int    hold_left = 0;

	signed_int_to_decimal_ascii_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_cnt++;
	endtask

	// queue the decimal text of one value
	function automatic void predict_text(input logic [VAL_W-1:0] raw);
		logic [VAL_W-1:0] mag;
		logic [3:0]       digs[NUM_DIGITS];
		int               nd;
		// most negative value wraps to 2^31, which fits unsigned
		mag = raw[VAL_W-1] ? (32'd0 - raw) : raw;
		nd  = 0;
		do begin
			digs[nd] = 4'(mag % 32'd10);
			mag      = mag / 32'd10;
			nd++;
		end while (mag != 0 && nd < NUM_DIGITS);
		if (raw[VAL_W-1])
			pending_chars.push_back(char_t'{CHAR_MINUS, 1'b0});
		for (int i = nd - 1; i >= 0; i--)
			pending_chars.push_back(char_t'{CHAR_ZERO + {2'b00, digs[i]}, i == 0});
	endfunction

	function automatic void push_typed(input string s);
		byte b;
		for (int i = 0; i < s.len(); i++) begin
			b = s[i];
			pending_chars.push_back(char_t'{b[CODE_W-1:0], i == s.len() - 1});
		end
	endfunction

	function automatic void add_row(input logic signed [VAL_W-1:0] v, input string t);
		values_q.push_back(row_t'{v, t});
	endfunction

	// character checker
	always @(posedge clk) begin
		char_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char %0d last %0b",
					char_code, last_char));
			end else begin
				want = pending_chars.pop_front();
				if (char_code !== want.code)
					report_mismatch($sformatf("char_code %0d, want %0d",
						char_code, want.code));
				if (last_char !== want.last)
					report_mismatch($sformatf("last_char %0b, want %0b",
						last_char, want.last));
			end
		end
	end

	// receiver: random stalls, one long hold-off, then a quiet stretch
	always @(posedge clk) begin
		rx_cyc++;
		if (rx_cyc == 1500)
			hold_left = 400;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (rx_cyc >= 3000 && rx_cyc < 4500) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 28);
		end
	end

	// sender
	initial begin
		logic [VAL_W-1:0] mag;
		longint unsigned  p;
		longint unsigned  hi;
		int               n;

		add_row(32'sd0,          "0");
		add_row(32'sd1,          "1");
		add_row(-32'sd1,         "-1");
		add_row(32'sd9,          "9");
		add_row(32'sd10,         "10");
		add_row(-32'sd10,        "");
		add_row(32'sd99,         "");
		add_row(32'sd100,        "");
		add_row(-32'sd7,         "");
		add_row(32'sd12345,      "");
		add_row(32'sd999999999,  "");
		add_row(32'sd1000000000, "");
		add_row(-32'sd999999999, "");
		add_row(-32'sd1000000000, "");
		add_row(32'h7FFF_FFFF,   "2147483647");
		add_row(32'h8000_0000,   "-2147483648");
		add_row(32'h8000_0001,   "-2147483647");
		add_row(32'h7FFF_FFFE,   "");
		add_row(32'h5555_5555,   "");
		add_row(32'hAAAA_AAAA,   "");
		add_row(32'sd0,          "0");

		for (int k = 0; k < 80; k++) begin
			if ($urandom_range(4) == 0) begin
				mag = $urandom;
			end else begin
				n = $urandom_range(10, 1);
				p = 1;
				repeat (n) p = p * 10;
				hi = (p - 1 > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : p - 1;
				mag = $urandom_range(32'(hi), 32'(p / 10));
				if ($urandom_range(1))
					mag = 32'd0 - mag;
			end
			add_row(mag, "");
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (values_q[k]) begin
			if (k < 40 || k > 75) begin
				while ($urandom_range(99) < 28) begin
					in_valid <= 1'b0;
					@(posedge clk);
				end
			end
			in_valid <= 1'b1;
			value    <= values_q[k].val;
			do @(posedge clk); while (in_stall);
			if (values_q[k].text.len() != 0)
				push_typed(values_q[k].text);
			else
				predict_text(values_q[k].val);
		end
		in_valid <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
